@@ hw/rtl/ptt_pkg.sv @@
// Shared types and constants for the priority task table.
package ptt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int ID_W = 20;
    localparam int PRI_W = 30;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXEC   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        AP_NONE  = 2'd0,
        AP_WRITE = 2'd1,
        AP_PRI   = 2'd2,
        AP_CLEAR = 2'd3
    } apply_kind_t;

    // Search results gathered as an item walks down the chain.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             best;
        logic [IDX_W-1:0] best_idx;
        logic [PRI_W-1:0] best_pri;
        logic [ID_W-1:0]  best_task;
        logic [ID_W-1:0]  best_user;
    } token_t;

    // Entry update broadcast to every cell once the search is complete.
    typedef struct packed {
        apply_kind_t      kind;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  task_id;
        logic [ID_W-1:0]  user_id;
        logic [PRI_W-1:0] pri;
    } apply_t;

endpackage

@@ hw/rtl/ptt_cell.sv @@
// One table entry plus the search stage that passes the token to the next cell.
module ptt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ptt_pkg::IDX_W-1:0]  cell_idx,
    input  logic [ptt_pkg::ID_W-1:0]   key,
    input  logic                       live_in,
    input  ptt_pkg::token_t            tok_in,
    input  ptt_pkg::apply_t            apply,
    output logic                       live_out,
    output ptt_pkg::token_t            tok_out
);

    logic                       valid_reg, valid_next;
    logic [ptt_pkg::ID_W-1:0]   task_reg, task_next;
    logic [ptt_pkg::ID_W-1:0]   user_reg, user_next;
    logic [ptt_pkg::PRI_W-1:0]  pri_reg, pri_next;
    logic                       live_reg;
    ptt_pkg::token_t            tok_reg, tok_next;
    logic                       sel;

    assign sel = (apply.kind != ptt_pkg::AP_NONE) && (apply.idx == cell_idx);

    always_comb
    begin
        valid_next = valid_reg;
        task_next  = task_reg;
        user_next  = user_reg;
        pri_next   = pri_reg;
        if (sel)
        begin
            unique case (apply.kind)
                ptt_pkg::AP_WRITE:
                begin
                    valid_next = 1'b1;
                    task_next  = apply.task_id;
                    user_next  = apply.user_id;
                    pri_next   = apply.pri;
                end
                ptt_pkg::AP_PRI:
                begin
                    pri_next = apply.pri;
                end
                ptt_pkg::AP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg && (task_reg == key) && !tok_in.hit)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
        end
        // The first free entry seen is the lowest-numbered one.
        if (!valid_reg && !tok_in.free)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = cell_idx;
        end
        if (valid_reg && (!tok_in.best || (pri_reg > tok_in.best_pri) ||
            ((pri_reg == tok_in.best_pri) && (task_reg > tok_in.best_task))))
        begin
            tok_next.best      = 1'b1;
            tok_next.best_idx  = cell_idx;
            tok_next.best_pri  = pri_reg;
            tok_next.best_task = task_reg;
            tok_next.best_user = user_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            live_reg  <= live_in;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        user_reg <= user_next;
        pri_reg  <= pri_next;
        tok_reg  <= tok_next;
    end

    assign live_out = live_reg;
    assign tok_out  = tok_reg;

endmodule

@@ hw/rtl/priority_task_table.sv @@
// Top level of the priority task table: command registers, cell chain and result logic.
//
//  channel   handshake        payload                                  direction
//  command   start / busy     operation, task_id, user_id, priority_req  in
//  result    done (strobe)    status, top_user                           out
//
// The accept loads the command registers and launch_reg; the search token then walks
// the cell chain one cell per cycle, and done is registered from the live flag that
// leaves the last cell. The entry update lands at the edge that raises done, and busy
// drops there, so the next item can be accepted at the edge that ends the done
// cycle; the block takes no new item while one is still in the chain.
// Reset clears every valid bit at once; there is no clearing pass.
// The receiver cannot stall: each result's done strobe stands for exactly one cycle.
module priority_task_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [19:0] task_id,
    input  logic [19:0] user_id,
    input  logic [29:0] priority_req,
    output logic        done,
    output logic [1:0]  status,
    output logic [19:0] top_user
);

    localparam int N = ptt_pkg::TABLE_ENTRIES;

    logic                       busy_reg, busy_next;
    logic                       launch_reg;
    ptt_pkg::op_t               op_reg;
    logic [ptt_pkg::ID_W-1:0]   key_reg;
    logic [ptt_pkg::ID_W-1:0]   user_reg;
    logic [ptt_pkg::PRI_W-1:0]  pri_reg;
    logic                       done_reg;
    ptt_pkg::status_t           status_reg, status_next;
    logic [ptt_pkg::ID_W-1:0]   top_user_reg, top_user_next;
    logic                       accept;
    logic                       last;
    ptt_pkg::token_t            tok_last;
    ptt_pkg::apply_t            apply;

    logic                       live_chain [0:N];
    ptt_pkg::token_t            tok_chain  [0:N];

    assign accept        = start && !busy_reg;
    assign live_chain[0] = launch_reg;
    assign tok_chain[0]  = '0;
    assign last          = live_chain[N];
    assign tok_last      = tok_chain[N];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ptt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (ptt_pkg::IDX_W'(k)),
            .key      (key_reg),
            .live_in  (live_chain[k]),
            .tok_in   (tok_chain[k]),
            .apply    (apply),
            .live_out (live_chain[k+1]),
            .tok_out  (tok_chain[k+1])
        );
    end

    // Decide the outcome once the token leaves the last cell.
    always_comb
    begin
        apply.kind    = ptt_pkg::AP_NONE;
        apply.idx     = tok_last.hit_idx;
        apply.task_id = key_reg;
        apply.user_id = user_reg;
        apply.pri     = pri_reg;
        status_next   = ptt_pkg::ST_OK;
        top_user_next = '0;
        unique case (op_reg)
            ptt_pkg::OP_ADD:
            begin
                if (tok_last.hit)
                begin
                    apply.kind = ptt_pkg::AP_WRITE;
                end
                else if (tok_last.free)
                begin
                    apply.kind = ptt_pkg::AP_WRITE;
                    apply.idx  = tok_last.free_idx;
                end
                else
                begin
                    status_next = ptt_pkg::ST_FULL;
                end
            end
            ptt_pkg::OP_EDIT:
            begin
                if (tok_last.hit)
                    apply.kind = ptt_pkg::AP_PRI;
                else
                    status_next = ptt_pkg::ST_NOT_FOUND;
            end
            ptt_pkg::OP_REMOVE:
            begin
                if (tok_last.hit)
                    apply.kind = ptt_pkg::AP_CLEAR;
                else
                    status_next = ptt_pkg::ST_NOT_FOUND;
            end
            ptt_pkg::OP_EXEC:
            begin
                if (tok_last.best)
                begin
                    apply.kind    = ptt_pkg::AP_CLEAR;
                    apply.idx     = tok_last.best_idx;
                    top_user_next = tok_last.best_user;
                end
                else
                begin
                    status_next = ptt_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ptt_pkg::ST_OK;
            end
        endcase
        if (!last)
            apply.kind = ptt_pkg::AP_NONE;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= accept;
            done_reg   <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= ptt_pkg::op_t'(operation);
            key_reg  <= task_id;
            user_reg <= user_id;
            pri_reg  <= priority_req;
        end
        if (last)
        begin
            status_reg   <= status_next;
            top_user_reg <= top_user_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign status   = status_reg;
    assign top_user = top_user_reg;

endmodule

@@ hw/rtl/ptt_checker.sv @@
// Port-level checks for the priority task table and the bind that attaches them.
module ptt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [19:0] top_user
);

    // A result strobe never lasts more than one cycle, since every item spans the chain.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Busy drops only at the edge that delivers the item's result.
    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_user_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ptt_pkg::ST_OK)) |-> (top_user == 20'd0))
        else $error("top_user nonzero on a failed command");

endmodule

bind priority_task_table ptt_checker u_ptt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .top_user (top_user)
);
